>>> hw/rtl/bus_pkg.sv
`timescale 1ns / 1ps

package bus_pkg;

	// Command codes of an input word
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_RX    = 2'd1,
		CMD_SLOT  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	// Transmit sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_BEGIN_CMD  = 3'd1,
		PH_BEGIN_FLAG = 3'd2,
		PH_DATA_HEAD  = 3'd3,
		PH_PAYLOAD    = 3'd4,
		PH_SUM_HI     = 3'd5,
		PH_SUM_LO     = 3'd6,
		PH_END        = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		OUT_RUN  = 2'd0,
		OUT_OK   = 2'd1,
		OUT_FAIL = 2'd2,
		OUT_RSVD = 2'd3
	} outcome_t;

	// Link bytes
	localparam logic [7:0] BYTE_BEGIN = 8'h01;
	localparam logic [7:0] BYTE_DATA  = 8'h02;
	localparam logic [7:0] BYTE_ACK   = 8'h03;
	localparam logic [7:0] BYTE_END   = 8'h04;
	localparam logic [7:0] BYTE_NAK   = 8'h05;
	localparam logic [7:0] BYTE_PAD   = 8'hFF;

	// Configuration register map
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 18;
	localparam int LEN_W      = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERIFY_REQUEST = 1'd1;

endpackage

>>> hw/rtl/bus_if.sv
`timescale 1ns / 1ps

// Input word channel
interface bus_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] rx_byte;
	logic [7:0] image_byte;

	modport source (output valid, output cmd, output rx_byte, output image_byte, input ready);
	modport sink   (input valid, input cmd, input rx_byte, input image_byte, output ready);
endinterface

// Result word channel
interface bus_result_if;
	logic       valid;
	logic       ready;
	logic       tx_valid;
	logic [7:0] tx_byte;
	logic       image_taken;
	logic [1:0] outcome;

	modport source (output valid, output tx_valid, output tx_byte, output image_taken,
		output outcome, input ready);
	modport sink   (input valid, input tx_valid, input tx_byte, input image_taken,
		input outcome, output ready);
endinterface

// Configuration write channel
interface bus_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bus_pkg::CFG_IDX_W-1:0]  index;
	logic [bus_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/block_upload_sender_core.sv
`timescale 1ns / 1ps

// Block upload sender.
// item_in carries one word per event: start, a byte received from the target, a
// transmit slot, or no operation. result_out gives exactly one word back per input
// word: tx_valid/tx_byte for a byte sent in a slot, image_taken when image_byte was
// consumed into the payload, and the session outcome (running, success, failure).
// cfg writes image_length (index 0) and verify_request (index 1); always ready.
// The user must write only while no word is in flight; the block does not enforce this.
// An accepted word passes the input register, then the result register, before it
// shows on result_out. Throughput: one word per cycle while result_out.ready is high;
// the whole per-word update of the sequencer is one pass of logic between the registers.
// Stall: when result_out.ready is low the result register holds, the input register
// fills behind it, and item_in.ready drops only once both are full.
// Reset: sequencer idle with no session, outcome running, image_length 0 and
// verify_request 1.
// Block totals are worked out by comparing the image length with the running end
// offset of the current block, so no divider is needed.

module block_upload_sender_core #(
	parameter int BLOCK_BYTES = 512,
	parameter int MAX_BLOCKS  = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	bus_item_if.sink              item_in,
	bus_result_if.source          result_out,
	bus_cfg_if.sink               cfg
);

	localparam int IW        = $clog2(BLOCK_BYTES + 1);
	localparam int BW        = $clog2(MAX_BLOCKS + 1);
	localparam int CAP_BYTES = MAX_BLOCKS * BLOCK_BYTES;
	localparam int EW        = $clog2(CAP_BYTES + 1);
	// wide enough for a block base plus byte index and for the image length
	localparam int CW        = ((EW > bus_pkg::LEN_W) ? EW : bus_pkg::LEN_W) + 1;

	// configuration
	logic [bus_pkg::LEN_W-1:0] img_len_q;
	logic                      verify_q;

	// input stage
	logic       vld_s1;
	logic [1:0] cmd_s1;
	logic [7:0] rx_s1;
	logic [7:0] img_s1;

	// result stage
	logic       vld_s2;
	logic       tx_valid_s2;
	logic [7:0] tx_byte_s2;
	logic       taken_s2;
	logic [1:0] outcome_s2;

	// sequencer state
	bus_pkg::phase_t   phase_q, phase_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic [BW-1:0]     bs_q, bs_d;
	logic [CW-1:0]     blk_end_q, blk_end_d;   // blocks_sent * BLOCK_BYTES
	logic [15:0]       sum_q, sum_d;
	logic              begun_q, begun_d;
	logic              flag_q, flag_d;
	bus_pkg::outcome_t outc_q, outc_d;
	logic              sess_q, sess_d;

	// per-word results
	logic       tx_valid_d;
	logic [7:0] tx_byte_d;
	logic       taken_d;

	logic          adv;
	logic [CW-1:0] len_ext;
	logic [CW-1:0] blk_base;
	logic          capped;
	logic          in_last;
	logic          take_ok;
	logic          all_sent;

	// result register frees up when empty or being read out
	assign adv          = vld_s1 && (!vld_s2 || result_out.ready);
	assign item_in.ready = !vld_s1 || adv;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_len_q <= '0;
			verify_q  <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bus_pkg::CFG_IMAGE_LENGTH:   img_len_q <= cfg.data;
				bus_pkg::CFG_VERIFY_REQUEST: verify_q  <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_in.ready) begin
			vld_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.ready && item_in.valid) begin
			cmd_s1 <= item_in.cmd;
			rx_s1  <= item_in.rx_byte;
			img_s1 <= item_in.image_byte;
		end
	end

	// block bookkeeping, all by compare against end-of-block offsets
	assign len_ext  = CW'(img_len_q);
	assign blk_base = blk_end_q - CW'(BLOCK_BYTES);
	assign capped   = len_ext > CW'(CAP_BYTES);
	// current block is the short last one
	assign in_last  = !capped && (blk_base < len_ext) && (len_ext < blk_end_q);
	assign take_ok  = !in_last || ((blk_base + CW'(idx_q)) < len_ext);
	assign all_sent = capped ? (bs_q >= BW'(MAX_BLOCKS)) : (blk_end_q >= len_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= bus_pkg::PH_IDLE;
			idx_q     <= '0;
			bs_q      <= '0;
			blk_end_q <= '0;
			sum_q     <= '0;
			begun_q   <= 1'b0;
			flag_q    <= 1'b0;
			outc_q    <= bus_pkg::OUT_RUN;
			sess_q    <= 1'b0;
		end else if (adv) begin
			phase_q   <= phase_d;
			idx_q     <= idx_d;
			bs_q      <= bs_d;
			blk_end_q <= blk_end_d;
			sum_q     <= sum_d;
			begun_q   <= begun_d;
			flag_q    <= flag_d;
			outc_q    <= outc_d;
			sess_q    <= sess_d;
		end
	end

	always_comb begin
		phase_d    = phase_q;
		idx_d      = idx_q;
		bs_d       = bs_q;
		blk_end_d  = blk_end_q;
		sum_d      = sum_q;
		begun_d    = begun_q;
		flag_d     = flag_q;
		outc_d     = outc_q;
		sess_d     = sess_q;
		tx_valid_d = 1'b0;
		tx_byte_d  = '0;
		taken_d    = 1'b0;

		unique case (bus_pkg::cmd_t'(cmd_s1))
			bus_pkg::CMD_START: begin
				// restart a session from scratch
				phase_d   = bus_pkg::PH_BEGIN_CMD;
				idx_d     = '0;
				bs_d      = '0;
				blk_end_d = '0;
				sum_d     = '0;
				begun_d   = 1'b0;
				flag_d    = verify_q;
				outc_d    = bus_pkg::OUT_RUN;
				sess_d    = 1'b1;
			end
			bus_pkg::CMD_RX: begin
				// replies count only between frames of a live session
				if (sess_q && phase_q == bus_pkg::PH_IDLE) begin
					if (rx_s1 == bus_pkg::BYTE_ACK) begin
						if (all_sent) begin
							phase_d = bus_pkg::PH_END;
							outc_d  = bus_pkg::OUT_OK;
							sess_d  = 1'b0;
						end else begin
							begun_d   = 1'b1;
							bs_d      = bs_q + BW'(1);
							blk_end_d = blk_end_q + CW'(BLOCK_BYTES);
							idx_d     = '0;
							sum_d     = '0;
							phase_d   = bus_pkg::PH_DATA_HEAD;
						end
					end else if (rx_s1 == bus_pkg::BYTE_NAK) begin
						if (begun_q) begin
							outc_d = bus_pkg::OUT_FAIL;
							sess_d = 1'b0;
						end else begin
							flag_d  = 1'b0;
							phase_d = bus_pkg::PH_BEGIN_CMD;
						end
					end
				end
			end
			bus_pkg::CMD_SLOT: begin
				tx_valid_d = (phase_q != bus_pkg::PH_IDLE);
				unique case (phase_q)
					bus_pkg::PH_IDLE: ;
					bus_pkg::PH_BEGIN_CMD: begin
						tx_byte_d = bus_pkg::BYTE_BEGIN;
						phase_d   = bus_pkg::PH_BEGIN_FLAG;
					end
					bus_pkg::PH_BEGIN_FLAG: begin
						tx_byte_d = {7'd0, flag_q};
						phase_d   = bus_pkg::PH_IDLE;
					end
					bus_pkg::PH_DATA_HEAD: begin
						tx_byte_d = bus_pkg::BYTE_DATA;
						phase_d   = bus_pkg::PH_PAYLOAD;
					end
					bus_pkg::PH_PAYLOAD: begin
						// image data, or pad past the end of a short last block
						if (take_ok) begin
							tx_byte_d = img_s1;
							taken_d   = 1'b1;
						end else begin
							tx_byte_d = bus_pkg::BYTE_PAD;
						end
						sum_d = sum_q + {8'd0, tx_byte_d};
						idx_d = idx_q + IW'(1);
						if (idx_q == IW'(BLOCK_BYTES - 1)) begin
							phase_d = bus_pkg::PH_SUM_HI;
						end
					end
					bus_pkg::PH_SUM_HI: begin
						tx_byte_d = sum_q[15:8];
						phase_d   = bus_pkg::PH_SUM_LO;
					end
					bus_pkg::PH_SUM_LO: begin
						tx_byte_d = sum_q[7:0];
						phase_d   = bus_pkg::PH_IDLE;
					end
					bus_pkg::PH_END: begin
						tx_byte_d = bus_pkg::BYTE_END;
						phase_d   = bus_pkg::PH_IDLE;
					end
					default: ;
				endcase
			end
			bus_pkg::CMD_NOP: ;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (result_out.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tx_valid_s2 <= tx_valid_d;
			tx_byte_s2  <= tx_byte_d;
			taken_s2    <= taken_d;
			outcome_s2  <= outc_d;
		end
	end

	assign result_out.valid       = vld_s2;
	assign result_out.tx_valid    = tx_valid_s2;
	assign result_out.tx_byte     = tx_byte_s2;
	assign result_out.image_taken = taken_s2;
	assign result_out.outcome     = outcome_s2;

endmodule

>>> verif/tb_block_upload_sender_core.sv
`timescale 1ns / 1ps

// Self-checking bench for the block upload sender.
// Input words are queued by the stimulus process and fed to the core by a clocked
// driver; every accepted word is also run through a behavioural copy of the sender,
// and the word it should give back is queued. A clocked monitor takes result words,
// with random back-pressure, and compares them field by field in order.

module tb_block_upload_sender_core;

	localparam int BLOCK_BYTES  = 512;
	localparam int MAX_BLOCKS   = 256;
	localparam int HOLD_CYCLES  = 64;   // one long receiver hold-off, fills both registers
	localparam int SHOWN_ERRORS = 200;  // keep the log readable on a systematic fault

	typedef struct packed {
		bus_pkg::cmd_t cmd;
		logic [7:0]    rx_byte;
		logic [7:0]    image_byte;
	} link_word_t;

	typedef struct packed {
		logic              tx_valid;
		logic [7:0]        tx_byte;
		logic              image_taken;
		bus_pkg::outcome_t outcome;
	} link_result_t;

	// How a generated session is allowed to end
	typedef enum {PLAN_ANY, PLAN_OK, PLAN_EARLY_NAK} plan_t;
	typedef enum {FINISH_OK, FINISH_NAK, FINISH_CUT} finish_t;

	logic clk = 1'b0;
	logic arst_n;

	bus_item_if   item_if();
	bus_result_if res_if();
	bus_cfg_if    cfg_if();

	block_upload_sender_core #(
		.BLOCK_BYTES(BLOCK_BYTES),
		.MAX_BLOCKS (MAX_BLOCKS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_if),
		.result_out(res_if),
		.cfg       (cfg_if)
	);

	// Words waiting to be offered, and result words still owed by the core
	link_word_t   pending_words[$];
	link_result_t expected_results[$];
	link_word_t   next_word;
	link_result_t got, want;

	// Shadow of the sender: sequencer state plus our copy of the two registers
	bus_pkg::phase_t   st_phase   = bus_pkg::PH_IDLE;
	logic [9:0]        st_index   = '0;
	logic [8:0]        st_blocks  = '0;
	logic [15:0]       st_sum     = '0;
	logic              st_begun   = 1'b0;
	logic              st_flag    = 1'b0;
	logic              st_active  = 1'b0;
	bus_pkg::outcome_t st_outcome = bus_pkg::OUT_RUN;
	logic [17:0]       cfg_len    = '0;
	logic              cfg_verify = 1'b1;

	// Idling control
	bit          no_idle = 1'b0;
	int unsigned send_gap, recv_gap, hold_left;
	int unsigned hold_at;

	// Bookkeeping for the summary
	int unsigned errors;
	int unsigned words_in, results_seen, link_bytes, image_bytes;
	int unsigned sessions_ok, sessions_nak, sessions_cut;

	// Clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Reset once, inputs known from time zero
	initial begin
		arst_n           = 1'b0;
		item_if.valid    = 1'b0;
		item_if.cmd      = bus_pkg::CMD_NOP;
		item_if.rx_byte  = '0;
		item_if.image_byte = '0;
		res_if.ready     = 1'b0;
		cfg_if.valid     = 1'b0;
		cfg_if.index     = '0;
		cfg_if.data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Timed out with %0d words queued and %0d results owed",
			pending_words.size(), expected_results.size());
		$display("** block_upload_sender_core: FAILED **");
		$finish;
	end

	// Mostly no gap, some short ones, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 2)
			return $urandom_range(40, 8);
		if (r < 22)
			return $urandom_range(3, 1);
		return 0;
	endfunction

	// Blocks the image occupies, capped at MAX_BLOCKS
	function automatic int unsigned image_blocks(input logic [17:0] len);
		int unsigned n;
		n = (int'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
		return (n > MAX_BLOCKS) ? MAX_BLOCKS : n;
	endfunction

	// Behavioural sender: advance the shadow by one input word, return the result word
	function automatic link_result_t predict_sender(input link_word_t w);
		link_result_t r;
		int unsigned  rem, raw_blocks, total, fill;
		logic         capped;
		rem        = cfg_len % BLOCK_BYTES;
		raw_blocks = cfg_len / BLOCK_BYTES + ((rem != 0) ? 1 : 0);
		capped     = raw_blocks > MAX_BLOCKS;
		total      = capped ? MAX_BLOCKS : raw_blocks;
		r = '0;
		case (w.cmd)
		bus_pkg::CMD_START: begin
			// a start always wins, whatever was under way
			st_phase   = bus_pkg::PH_BEGIN_CMD;
			st_index   = '0;
			st_blocks  = '0;
			st_sum     = '0;
			st_begun   = 1'b0;
			st_flag    = cfg_verify;
			st_outcome = bus_pkg::OUT_RUN;
			st_active  = 1'b1;
		end
		bus_pkg::CMD_RX: begin
			// replies only count in a live session with nothing left to send
			if (st_active && st_phase == bus_pkg::PH_IDLE) begin
				if (w.rx_byte == bus_pkg::BYTE_ACK) begin
					if (st_blocks >= total) begin
						st_phase   = bus_pkg::PH_END;
						st_outcome = bus_pkg::OUT_OK;
						st_active  = 1'b0;
					end else begin
						st_begun  = 1'b1;
						st_blocks = st_blocks + 1'b1;
						st_index  = '0;
						st_sum    = '0;
						st_phase  = bus_pkg::PH_DATA_HEAD;
					end
				end else if (w.rx_byte == bus_pkg::BYTE_NAK) begin
					if (st_begun) begin
						st_outcome = bus_pkg::OUT_FAIL;
						st_active  = 1'b0;
					end else begin
						// refused before any data: offer again without verify
						st_flag  = 1'b0;
						st_phase = bus_pkg::PH_BEGIN_CMD;
					end
				end
			end
		end
		bus_pkg::CMD_SLOT: begin
			if (st_phase != bus_pkg::PH_IDLE) begin
				r.tx_valid = 1'b1;
				case (st_phase)
				bus_pkg::PH_BEGIN_CMD: begin
					r.tx_byte = bus_pkg::BYTE_BEGIN;
					st_phase  = bus_pkg::PH_BEGIN_FLAG;
				end
				bus_pkg::PH_BEGIN_FLAG: begin
					r.tx_byte = {7'd0, st_flag};
					st_phase  = bus_pkg::PH_IDLE;
				end
				bus_pkg::PH_DATA_HEAD: begin
					r.tx_byte = bus_pkg::BYTE_DATA;
					st_phase  = bus_pkg::PH_PAYLOAD;
				end
				bus_pkg::PH_PAYLOAD: begin
					// short last block is padded, unless the block total was capped
					fill = (!capped && rem != 0 && st_blocks == total) ? rem : BLOCK_BYTES;
					if (st_index < fill) begin
						r.tx_byte     = w.image_byte;
						r.image_taken = 1'b1;
					end else begin
						r.tx_byte = bus_pkg::BYTE_PAD;
					end
					st_sum   = st_sum + r.tx_byte;
					st_index = st_index + 1'b1;
					if (st_index >= BLOCK_BYTES)
						st_phase = bus_pkg::PH_SUM_HI;
				end
				bus_pkg::PH_SUM_HI: begin
					r.tx_byte = st_sum[15:8];
					st_phase  = bus_pkg::PH_SUM_LO;
				end
				bus_pkg::PH_SUM_LO: begin
					r.tx_byte = st_sum[7:0];
					st_phase  = bus_pkg::PH_IDLE;
				end
				default: begin
					r.tx_byte = bus_pkg::BYTE_END;
					st_phase  = bus_pkg::PH_IDLE;
				end
				endcase
			end
		end
		default: ;
		endcase
		r.outcome = st_outcome;
		return r;
	endfunction

	// Driver: offers queued words; the model is stepped on each accepted word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_if.valid      <= 1'b0;
			item_if.cmd        <= bus_pkg::CMD_NOP;
			item_if.rx_byte    <= '0;
			item_if.image_byte <= '0;
			send_gap           <= 0;
		end else begin
			if (item_if.valid && item_if.ready) begin
				expected_results.push_back(predict_sender(link_word_t'{
					bus_pkg::cmd_t'(item_if.cmd), item_if.rx_byte, item_if.image_byte}));
				words_in++;
			end
			// a word not yet taken stays on the bus untouched
			if (!item_if.valid || item_if.ready) begin
				if (send_gap != 0) begin
					item_if.valid <= 1'b0;
					send_gap      <= send_gap - 1;
				end else if (pending_words.size() != 0) begin
					next_word          = pending_words.pop_front();
					item_if.valid      <= 1'b1;
					item_if.cmd        <= next_word.cmd;
					item_if.rx_byte    <= next_word.rx_byte;
					item_if.image_byte <= next_word.image_byte;
					send_gap           <= no_idle ? 0 : pick_gap();
				end else begin
					item_if.valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input logic [7:0] exp_v,
		input logic [7:0] act_v);
		if (act_v !== exp_v) begin
			errors++;
			if (errors <= SHOWN_ERRORS)
				$display("%0t: %s mismatch on result %0d, expected %0h, got %0h",
					$time, what, results_seen, exp_v, act_v);
			else if (errors == SHOWN_ERRORS + 1)
				$display("%0t: further mismatches not shown", $time);
		end
	endtask

	// Long receiver hold-off, counted here; the sender keeps offering meanwhile
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_at   <= 40;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (results_seen >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_at   <= hold_at * 40;
		end
	end

	// Monitor: takes result words and checks them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			recv_gap     <= 0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				got = link_result_t'{res_if.tx_valid, res_if.tx_byte, res_if.image_taken,
					bus_pkg::outcome_t'(res_if.outcome)};
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= SHOWN_ERRORS)
						$display("%0t: result word with none expected, expected nothing, got %0h",
							$time, got);
				end else begin
					want = expected_results.pop_front();
					check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
					check_field("tx_byte", want.tx_byte, got.tx_byte);
					check_field("image_taken", 8'(want.image_taken), 8'(got.image_taken));
					check_field("outcome", 8'(want.outcome), 8'(got.outcome));
				end
				results_seen++;
				if (got.tx_valid)
					link_bytes++;
				if (got.image_taken)
					image_bytes++;
			end
			if (hold_left != 0) begin
				res_if.ready <= 1'b0;
			end else if (recv_gap != 0) begin
				res_if.ready <= 1'b0;
				recv_gap     <= recv_gap - 1;
			end else begin
				res_if.ready <= 1'b1;
				recv_gap     <= no_idle ? 0 : pick_gap();
			end
		end
	end

	task automatic add_word(input bus_pkg::cmd_t c, input logic [7:0] rx);
		logic [7:0] img;
		img = 8'($urandom);
		pending_words.push_back(link_word_t'{c, rx, img});
	endtask

	// Transmit slots; now and then a stray reply or no-op lands mid-frame
	task automatic add_slots(input int unsigned n);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(99) == 0)
				add_word($urandom_range(1) ? bus_pkg::CMD_NOP : bus_pkg::CMD_RX,
					8'($urandom));
			add_word(bus_pkg::CMD_SLOT, 8'($urandom));
		end
	endtask

	// Harmless words between frames: unknown reply byte, empty slot or no-op
	task automatic add_idle_noise();
		logic [7:0]  rx;
		int unsigned pick;
		pick = $urandom_range(9);
		rx   = 8'($urandom);
		if (rx == bus_pkg::BYTE_ACK || rx == bus_pkg::BYTE_NAK)
			rx = rx ^ 8'h80;
		case (pick)
		0: add_word(bus_pkg::CMD_RX, rx);
		1: add_word(bus_pkg::CMD_SLOT, rx);
		2: add_word(bus_pkg::CMD_NOP, rx);
		default: ;
		endcase
	endtask

	// One upload as the target would answer it, sized from the current image length.
	// Not fresh: the begin frame has already gone out.
	task automatic queue_session(input bit fresh, input plan_t plan);
		int unsigned nb, stop_at;
		finish_t     fin;
		int unsigned r;
		nb = image_blocks(cfg_len);
		if (fresh) begin
			add_word(bus_pkg::CMD_START, 8'($urandom));
			add_slots(2);
			if ($urandom_range(3) == 0) begin
				add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_NAK);
				add_slots(2);
			end
		end
		r = $urandom_range(99);
		if (plan == PLAN_OK || nb == 0 || (plan == PLAN_ANY && r < 70))
			fin = FINISH_OK;
		else if (plan == PLAN_EARLY_NAK || r < 85)
			fin = FINISH_NAK;
		else
			fin = FINISH_CUT;
		stop_at = (fin == FINISH_OK) ? nb : $urandom_range(nb, 1);
		if (plan == PLAN_EARLY_NAK && stop_at > 2)
			stop_at = 2;
		for (int unsigned b = 1; b <= stop_at; b++) begin
			add_idle_noise();
			add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);
			if (fin == FINISH_CUT && b == stop_at) begin
				// frame left half sent; the next start aborts it
				add_slots($urandom_range(BLOCK_BYTES + 2));
				sessions_cut++;
				return;
			end
			add_slots(BLOCK_BYTES + 3);
		end
		add_idle_noise();
		if (fin == FINISH_OK) begin
			add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);
			add_slots(1);
			sessions_ok++;
		end else begin
			add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_NAK);
			sessions_nak++;
		end
		// session over: a late reply is ignored, an empty slot sends nothing
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);
		add_word(bus_pkg::CMD_SLOT, 8'($urandom));
	endtask

	// Every queued word taken and answered
	task automatic wait_drained();
		while (pending_words.size() != 0 || item_if.valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bus_pkg::CFG_IDX_W-1:0] idx,
		input logic [bus_pkg::CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		do
			@(posedge clk);
		while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		if (idx == bus_pkg::CFG_IMAGE_LENGTH)
			cfg_len = value[17:0];
		else
			cfg_verify = value[0];
	endtask

	// Stimulus
	initial begin
		logic [17:0] vdata;
		wait (arst_n === 1'b1);
		@(posedge clk);

		// Directed, registers at reset values (empty image, verify on)
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);   // reply before any start
		add_word(bus_pkg::CMD_SLOT, 8'h00);             // nothing queued
		add_word(bus_pkg::CMD_NOP, 8'hFF);
		add_word(bus_pkg::CMD_START, 8'h00);
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_SLOT, 8'hFF);
		add_word(bus_pkg::CMD_RX, 8'h42);               // unknown reply
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);   // empty image: end byte, success at once
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);   // no session any more
		add_word(bus_pkg::CMD_SLOT, 8'h00);             // end byte still goes out
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_START, 8'hFF);            // new session clears the outcome
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_NAK);   // mid-frame, ignored
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_NAK);   // refused before data: no verify
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_RX, 8'h00);               // mid-frame, ignored
		add_word(bus_pkg::CMD_SLOT, 8'h00);
		add_word(bus_pkg::CMD_NOP, 8'h00);
		wait_drained();

		// Registers changed while that session is still open; one byte of image, so a frame
		// of that byte, padding, checksum and then success
		write_reg(bus_pkg::CFG_IMAGE_LENGTH, 18'd1);
		vdata    = 18'($urandom);
		vdata[0] = 1'b0;
		write_reg(bus_pkg::CFG_VERIFY_REQUEST, vdata);
		queue_session(1'b0, PLAN_OK);
		wait_drained();

		// Beyond the block cap, back to back: frame cut short by a restart
		no_idle = 1'b1;
		write_reg(bus_pkg::CFG_IMAGE_LENGTH, 18'h3FFFF);
		vdata    = 18'($urandom);
		vdata[0] = 1'b1;
		write_reg(bus_pkg::CFG_VERIFY_REQUEST, vdata);
		add_word(bus_pkg::CMD_START, 8'($urandom));
		add_slots(2);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);
		add_slots(24);
		sessions_cut++;
		add_word(bus_pkg::CMD_START, 8'($urandom));
		add_slots(1);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);   // mid-frame, ignored
		add_slots(1);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_NAK);
		add_slots(2);
		add_word(bus_pkg::CMD_RX, bus_pkg::BYTE_ACK);
		add_slots(8);

		wait_drained();
		repeat (10) @(posedge clk);
		$display("Covered %0d words in, %0d results, %0d link bytes sent, %0d image bytes taken",
			words_in, results_seen, link_bytes, image_bytes);
		$display("Uploads: %0d completed, %0d refused by the target, %0d cut by a restart",
			sessions_ok, sessions_nak, sessions_cut);
		if (errors == 0)
			$display("** block_upload_sender_core: PASSED **");
		else
			$display("** block_upload_sender_core: FAILED **");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/bus_pkg.sv
hw/rtl/bus_if.sv
hw/rtl/block_upload_sender_core.sv
verif/tb_block_upload_sender_core.sv
